@@ rtl/core/pwm_duty_measure_and_regenerate_core_macros.svh @@
// Assertion macros for the PWM duty measure core.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef PWM_DUTY_MEASURE_AND_REGENERATE_CORE_MACROS_SVH
`define PWM_DUTY_MEASURE_AND_REGENERATE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define PDMR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdmr check failed");
`define PDMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdmr check failed");
`else
`define PDMR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PDMR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/pdmr_pkg.sv @@
// Shared types and constants for the PWM duty measure core.
// No dependencies.
`timescale 1ns / 1ps

package pdmr_pkg;

    localparam int TIME_BITS    = 24;
    localparam int WINDOW_BITS  = 13;
    localparam int SUM_BITS     = WINDOW_BITS + 7;
    localparam int DUTY_BITS    = 8;
    localparam int PCT_BITS     = 7;
    localparam int PROD_BITS    = TIME_BITS + PCT_BITS;
    localparam int Q_BITS       = 9;
    localparam int STEP_BITS    = 4;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_BITS     = TIME_BITS;

    localparam logic [TIME_BITS-1:0]   TIME_MAX   = {TIME_BITS{1'b1}};
    localparam logic [WINDOW_BITS-1:0] WINDOW_MAX = WINDOW_BITS'(1) << (WINDOW_BITS - 1);
    localparam logic [DUTY_BITS-1:0]   DUTY_FULL  = {DUTY_BITS{1'b1}};
    localparam logic [TIME_BITS-1:0]   PCT_SCALE  = TIME_BITS'(100);

    localparam logic [STEP_BITS-1:0] PCT_STEPS = STEP_BITS'(PCT_BITS);
    localparam logic [STEP_BITS-1:0] SCL_STEPS = STEP_BITS'(Q_BITS);
    localparam logic [STEP_BITS-1:0] AVG_STEPS = STEP_BITS'(DUTY_BITS);

    localparam logic [DUTY_BITS-1:0]   FLOOR_RST   = DUTY_BITS'(2);
    localparam logic [DUTY_BITS-1:0]   CEILING_RST = DUTY_BITS'(245);
    localparam logic [WINDOW_BITS-1:0] WINDOW_RST  = WINDOW_BITS'(512);
    localparam logic [TIME_BITS-1:0]   TIMEOUT_RST = TIME_BITS'(393216);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FLOOR   = 2'd0,
        CFG_CEILING = 2'd1,
        CFG_WINDOW  = 2'd2,
        CFG_TIMEOUT = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PCT_LD,
        S_PCT,
        S_SCL_LD,
        S_SCL,
        S_AVG_LD,
        S_AVG,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [TIME_BITS-1:0] rem;
        logic [Q_BITS-1:0]    low;
        logic [TIME_BITS-1:0] divisor;
        logic [STEP_BITS-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [Q_BITS-1:0] quotient;
    } t_div_rsp;

endpackage

@@ rtl/core/pdmr_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on pdmr_pkg.
`timescale 1ns / 1ps

module pdmr_div import pdmr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [TIME_BITS-1:0] r_rem;
    logic [Q_BITS-1:0]    r_low;
    logic [TIME_BITS-1:0] r_div;
    logic [Q_BITS-1:0]    r_quo;
    logic [STEP_BITS-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [TIME_BITS:0]   w_trial;
    logic [TIME_BITS+1:0] w_diff;
    logic                 w_take;

    assign w_trial = {r_rem, r_low[Q_BITS-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_div};
    assign w_take  = !w_diff[TIME_BITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_BITS'(1);
                if (r_cnt == STEP_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem;
            r_low <= i_req.low;
            r_div <= i_req.divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_take ? w_diff[TIME_BITS-1:0] : w_trial[TIME_BITS-1:0];
            r_low <= {r_low[Q_BITS-2:0], 1'b0};
            r_quo <= {r_quo[Q_BITS-2:0], w_take};
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

@@ rtl/core/pwm_duty_measure_and_regenerate_core.sv @@
// Top level of the PWM duty measure and regenerate core: sequencer, state, output stage.
// Depends on pdmr_pkg, pdmr_div and the assertion macro header.
//
//  channel   dir  beat fields (low bit up)
//  s_axis    in   tdata[0] pin_level
//  m_axis    out  tdata[7:0] duty_value, [8] drive_enable, [9] duty_updated
//  cfg       in   index 0 floor, 1 ceiling, 2 window, 3 timeout; data low bits
//
// A tick without a closing rising edge goes from S_IDLE straight to S_FINISH.
// A closing edge runs the shared serial divider twice (7 and 9 bits); when
// the window fills, a third 8-bit average divide follows.
// Reset is synchronous, active low; config is held at its default values.
// m_axis has its own register, so a new sample is taken while a result waits.
`timescale 1ns / 1ps

`include "pwm_duty_measure_and_regenerate_core_macros.svh"

module pwm_duty_measure_and_regenerate_core import pdmr_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  logic [7:0]              i_s_axis_tdata,   // [0] pin_level
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    output logic [15:0]             o_m_axis_tdata,   // [7:0] duty_value, [8] drive_enable,
                                                      // [9] duty_updated
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]     i_cfg_data
);

    t_state r_state, n_state;

    logic [DUTY_BITS-1:0]   r_floor;
    logic [DUTY_BITS-1:0]   r_ceil;
    logic [WINDOW_BITS-1:0] r_window;
    logic [TIME_BITS-1:0]   r_timeout;

    logic                   r_last;
    logic                   r_armed;
    logic                   r_lae;
    logic [TIME_BITS-1:0]   r_elapsed;
    logic [TIME_BITS-1:0]   r_high;
    logic [SUM_BITS-1:0]    r_sum;
    logic [WINDOW_BITS-1:0] r_counted;
    logic [DUTY_BITS-1:0]   r_held;
    logic                   r_pulses;
    logic                   r_drive;
    logic                   r_upd;
    logic [PCT_BITS-1:0]    r_pct;

    logic                   r_m_valid;
    logic [DUTY_BITS-1:0]   r_m_duty;
    logic                   r_m_drive;
    logic                   r_m_upd;

    t_div_req w_req;
    t_div_rsp w_rsp;

    logic                   w_in_acc;
    logic                   w_lvl;
    logic                   w_close;
    logic [TIME_BITS-1:0]   w_el_inc;
    logic [WINDOW_BITS-1:0] w_win;
    logic [WINDOW_BITS-1:0] w_cnt_inc;
    logic [PROD_BITS-1:0]   w_high_x;
    logic [PROD_BITS-1:0]   w_prod;
    logic [DUTY_BITS-1:0]   w_q8;
    logic [DUTY_BITS-1:0]   w_avg_duty;
    logic                   w_out_free;
    logic                   w_load_out;
    logic                   w_to;
    logic                   w_pulses_n;
    logic                   w_force;
    logic                   w_turn_on;
    logic                   w_turn_off;
    logic                   w_drive_n;
    logic [DUTY_BITS-1:0]   w_held_n;
    logic                   w_div_wait;
    logic                   w_div_free;

    pdmr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // config
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor   <= FLOOR_RST;
            r_ceil    <= CEILING_RST;
            r_window  <= WINDOW_RST;
            r_timeout <= TIMEOUT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FLOOR:   r_floor   <= i_cfg_data[DUTY_BITS-1:0];
                CFG_CEILING: r_ceil    <= i_cfg_data[DUTY_BITS-1:0];
                CFG_WINDOW:  r_window  <= i_cfg_data[WINDOW_BITS-1:0];
                CFG_TIMEOUT: r_timeout <= i_cfg_data[TIME_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_window == '0) begin
            w_win = WINDOW_BITS'(1);
        end else if (r_window > WINDOW_MAX) begin
            w_win = WINDOW_MAX;
        end else begin
            w_win = r_window;
        end
    end

    // tick front end
    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_lvl     = i_s_axis_tdata[0];
    assign w_close   = w_lvl && !r_last && r_armed;
    assign w_el_inc  = (r_elapsed == TIME_MAX) ? r_elapsed : r_elapsed + TIME_BITS'(1);
    assign w_cnt_inc = r_counted + WINDOW_BITS'(1);

    // on * 100 by shift and add
    assign w_high_x = {{PCT_BITS{1'b0}}, r_high};
    assign w_prod   = (w_high_x << 6) + (w_high_x << 5) + (w_high_x << 2);

    assign w_q8 = w_rsp.quotient[Q_BITS-1] ? DUTY_FULL : w_rsp.quotient[DUTY_BITS-1:0];

    always_comb begin
        if (w_q8 < r_floor) begin
            w_avg_duty = '0;
        end else if (w_q8 >= r_ceil) begin
            w_avg_duty = DUTY_FULL;
        end else begin
            w_avg_duty = w_q8;
        end
    end

    // drive decision at the end of a tick
    assign w_out_free = !r_m_valid || i_m_axis_tready;
    assign w_to       = r_elapsed >= r_timeout;
    assign w_pulses_n = r_pulses && !w_to;
    assign w_force    = r_last && r_lae && w_to;
    assign w_turn_on  = !r_drive && (r_held > r_floor) && w_pulses_n;
    assign w_turn_off = r_drive && ((r_held <= r_floor) || !w_pulses_n);
    assign w_drive_n  = w_force || w_turn_on || (r_drive && !w_turn_off);
    assign w_held_n   = w_force ? DUTY_FULL : r_held;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_close ? S_PCT_LD : S_FINISH;
                end
            end
            S_PCT_LD: n_state = S_PCT;
            S_PCT: begin
                if (w_rsp.done) begin
                    n_state = S_SCL_LD;
                end
            end
            S_SCL_LD: n_state = S_SCL;
            S_SCL: begin
                if (w_rsp.done) begin
                    n_state = (w_cnt_inc >= w_win) ? S_AVG_LD : S_FINISH;
                end
            end
            S_AVG_LD: n_state = S_AVG;
            S_AVG: begin
                if (w_rsp.done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        w_load_out      = 1'b0;
        w_req           = '0;
        case (r_state)
            S_IDLE: o_s_axis_tready = i_rst_n;
            S_PCT_LD: begin
                w_req.start   = 1'b1;
                w_req.rem     = w_prod[PROD_BITS-1:PCT_BITS];
                w_req.low     = {w_prod[PCT_BITS-1:0], 2'b00};
                w_req.divisor = (r_elapsed == '0) ? TIME_BITS'(1) : r_elapsed;
                w_req.steps   = PCT_STEPS;
            end
            S_SCL_LD: begin
                w_req.start   = 1'b1;
                w_req.rem     = TIME_BITS'(r_pct[PCT_BITS-1:1]);
                w_req.low     = {r_pct[0], 8'h00};
                w_req.divisor = PCT_SCALE;
                w_req.steps   = SCL_STEPS;
            end
            S_AVG_LD: begin
                w_req.start   = 1'b1;
                w_req.rem     = TIME_BITS'(r_sum[SUM_BITS-1:DUTY_BITS]);
                w_req.low     = {r_sum[DUTY_BITS-1:0], 1'b0};
                w_req.divisor = TIME_BITS'(r_counted);
                w_req.steps   = AVG_STEPS;
            end
            S_FINISH: w_load_out = w_out_free;
            default: ;
        endcase
    end

    // measurement state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= 1'b0;
            r_armed   <= 1'b0;
            r_lae     <= 1'b0;
            r_elapsed <= '0;
            r_high    <= '0;
            r_sum     <= '0;
            r_counted <= '0;
            r_held    <= '0;
            r_pulses  <= 1'b0;
            r_drive   <= 1'b1;
            r_upd     <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_upd     <= 1'b0;
                        r_last    <= w_lvl;
                        r_elapsed <= w_el_inc;
                        if (w_lvl != r_last) begin
                            r_lae <= w_lvl;
                            if (w_lvl) begin
                                r_armed <= !r_armed;
                                if (!r_armed) begin
                                    r_elapsed <= '0;
                                    r_high    <= '0;
                                end
                            end else if (r_armed) begin
                                r_high <= w_el_inc;
                            end
                        end
                    end
                end
                S_SCL: begin
                    if (w_rsp.done) begin
                        r_sum     <= r_sum + SUM_BITS'(w_q8);
                        r_counted <= w_cnt_inc;
                    end
                end
                S_AVG: begin
                    if (w_rsp.done) begin
                        r_held    <= w_avg_duty;
                        r_pulses  <= 1'b1;
                        r_sum     <= '0;
                        r_counted <= '0;
                        r_upd     <= 1'b1;
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_pulses <= w_pulses_n;
                        r_drive  <= w_drive_n;
                        r_held   <= w_held_n;
                        if (!w_force && !w_turn_on && w_turn_off) begin
                            r_sum     <= '0;
                            r_counted <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PCT && w_rsp.done) begin
            r_pct <= w_rsp.quotient[PCT_BITS-1:0];
        end
    end

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load_out) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_m_duty  <= w_held_n;
            r_m_drive <= w_drive_n;
            r_m_upd   <= r_upd;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {6'b000000, r_m_upd, r_m_drive, r_m_duty};

    assign w_div_wait = (r_state == S_PCT) || (r_state == S_SCL) || (r_state == S_AVG);
    assign w_div_free = (r_state == S_IDLE) || (r_state == S_FINISH);

    `PDMR_ASSERT_IMPL(a_done_in_wait, i_clk, i_rst_n, w_rsp.done, w_div_wait)
    `PDMR_ASSERT_IMPL(a_div_idle_at_end, i_clk, i_rst_n, w_div_free, !w_rsp.busy)
    `PDMR_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, w_in_acc, r_state != S_IDLE)

endmodule
